@@ rtl/banded_lu_linear_solver_assert.svh @@
// assertion macros for the banded lu solver checker
`ifndef BANDED_LU_LINEAR_SOLVER_ASSERT_SVH
`define BANDED_LU_LINEAR_SOLVER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define BLU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BLU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/blu_pkg.sv @@
// shared types, constants and fixed-point helpers of the banded lu solver
`timescale 1ns / 1ps
`default_nettype none

package blu_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int WIDE_W       = 50;
    localparam int DET_W        = 64;
    localparam int IDX_W        = 6;

    localparam logic [DET_W-1:0] DET_ONE = 64'h0000_0001_0000_0000;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_ZERO_PIVOT = 2'd1,
        ERR_ROW_LIMIT  = 2'd2,
        ERR_SATURATE   = 2'd3
    } err_t;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } su_req_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROW_RD,
        ST_ROW_M1,
        ST_ROW_M2,
        ST_ROW_M3,
        ST_ROW_CHK,
        ST_ROW_DIV,
        ST_DET_HI,
        ST_DET_LO,
        ST_ROW_WR,
        ST_POST,
        ST_BS_RD,
        ST_BS_M1,
        ST_BS_M2,
        ST_BS_CHK,
        ST_BS_DIV,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_OUT_WAIT
    } state_t;

    // magnitude of a two's complement word, most negative value included
    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 1'b1) : x;
    endfunction

    // sign extension into the wide working width
    function automatic logic [WIDE_W-1:0] sext32(input logic [DATA_W-1:0] x);
        return {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
    endfunction

    // true when a wide value lies inside the 32-bit signed range
    function automatic logic fits32(input logic [WIDE_W-1:0] v);
        return (&v[WIDE_W-1:DATA_W-1]) | ~(|v[WIDE_W-1:DATA_W-1]);
    endfunction

    // raw magnitude product to signed q16.16, rounded half away from zero
    function automatic logic [WIDE_W-1:0] qmul_res(input logic [63:0] p, input logic neg);
        logic [63:0]       t;
        logic [WIDE_W-1:0] r;
        t = p + 64'd32768;
        r = {2'b00, t[63:16]};
        return neg ? (~r + 1'b1) : r;
    endfunction

    // truncated magnitude quotient to signed value
    function automatic logic [WIDE_W-1:0] qdiv_res(input logic [63:0] q, input logic neg);
        logic [WIDE_W-1:0] r;
        r = {2'b00, q[47:0]};
        return neg ? (~r + 1'b1) : r;
    endfunction

    // q32.32 times q16.16 from the two partial products, clamped to 64 bits
    function automatic logic [DET_W-1:0] det_update(input logic [63:0] hp,
                                                    input logic [63:0] plo,
                                                    input logic        neg);
        logic [63:0] lim;
        logic [63:0] t;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (hp >= 64'h0000_8000_0000_0000)
        begin
            t = lim;
        end
        else
        begin
            t = (hp << 16) + ((plo + 64'd32768) >> 16);
        end
        if (t > lim)
        begin
            t = lim;
        end
        return neg ? (~t + 1'b1) : t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/blu_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module blu_ram #(
    parameter int  WIDTH = blu_pkg::DATA_W,
    parameter int  DEPTH = blu_pkg::MAX_ROWS_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/blu_serial_unit.sv @@
// bit-serial magnitude multiplier and restoring divider, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module blu_serial_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire blu_pkg::su_req_t            req,
    input  wire logic [blu_pkg::DATA_W-1:0]  opa,
    input  wire logic [blu_pkg::DATA_W-1:0]  opb,
    output logic                             done,
    output logic [63:0]                      result
);

    localparam int MUL_STEPS = blu_pkg::DATA_W;
    localparam int DIV_STEPS = blu_pkg::DATA_W + 16;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    blu_pkg::op_t                op_reg, op_next;
    logic [5:0]                  cnt_reg, cnt_next;
    logic [63:0]                 acc_reg, acc_next;
    logic [blu_pkg::DATA_W-1:0]  opd_reg, opd_next;
    logic [blu_pkg::DATA_W:0]    rem_reg, rem_next;

    logic [blu_pkg::DATA_W:0]    mul_sum;
    logic [blu_pkg::DATA_W:0]    div_shift;
    logic [blu_pkg::DATA_W+1:0]  div_diff;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= blu_pkg::OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opd_reg <= opd_next;
        rem_reg <= rem_next;
    end

    // one shift-add or one trial subtract per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        opd_next  = opd_reg;
        rem_next  = rem_reg;

        mul_sum   = {1'b0, acc_reg[63:32]} + (acc_reg[0] ? {1'b0, opd_reg} : '0);
        div_shift = {rem_reg[blu_pkg::DATA_W-1:0], acc_reg[47]};
        div_diff  = {1'b0, div_shift} - {2'b00, opd_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            rem_next  = '0;
            if (req.op == blu_pkg::OP_MUL)
            begin
                acc_next = {32'd0, opb};
                opd_next = opa;
                cnt_next = 6'(MUL_STEPS);
            end
            else
            begin
                acc_next = {16'd0, opa, 16'd0};
                opd_next = opb;
                cnt_next = 6'(DIV_STEPS);
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == blu_pkg::OP_MUL)
            begin
                acc_next = {mul_sum, acc_reg[31:1]};
            end
            else if (!div_diff[blu_pkg::DATA_W+1])
            begin
                rem_next = div_diff[blu_pkg::DATA_W:0];
                acc_next = {16'd0, acc_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = div_shift;
                acc_next = {16'd0, acc_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule

`default_nettype wire

@@ rtl/banded_lu_linear_solver.sv @@
// banded lu solver: top level with row sequencer, band stores and output register
//
// Input channel (in_valid/in_ready) takes one matrix row per request: sub_diag,
// diag, super_one, super_two, rhs in q16.16 and last_row. in_ready is high only
// while the sequencer is idle, so one row is worked on at a time.
// Each row runs three serial multiplies, one serial divide and two multiplies
// for the determinant on a single shared bit-serial unit that works one bit
// per cycle; the last row has no divide. After the last row comes back
// substitution, then results leave on the output channel (out_valid/out_ready)
// from the highest row down to row 0.
// On an error exactly one result leaves: zero payload, the error code, last set.
// A stalled receiver holds the output register and the whole sequencer; no row
// is taken until the final result of a solve has been accepted.
// Reset (rst_n low, asynchronous) empties the system: no rows held, determinant
// one, no error. The band stores need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module banded_lu_linear_solver #(
    parameter int MAX_ROWS = blu_pkg::MAX_ROWS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [blu_pkg::DATA_W-1:0]  sub_diag,
    input  wire logic [blu_pkg::DATA_W-1:0]  diag,
    input  wire logic [blu_pkg::DATA_W-1:0]  super_one,
    input  wire logic [blu_pkg::DATA_W-1:0]  super_two,
    input  wire logic [blu_pkg::DATA_W-1:0]  rhs,
    input  wire logic                        last_row,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [blu_pkg::DATA_W-1:0]       solution,
    output logic [blu_pkg::IDX_W-1:0]        row_index,
    output logic [blu_pkg::DET_W-1:0]        determinant,
    output logic [1:0]                       error_code,
    output logic                             last
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int DW = blu_pkg::DATA_W;
    localparam int WW = blu_pkg::WIDE_W;

    blu_pkg::state_t   state_reg, state_next;
    logic              launched_reg, launched_next;

    logic [DW-1:0]     sub_reg, sub_next;
    logic [DW-1:0]     diag_reg, diag_next;
    logic [DW-1:0]     s1_reg, s1_next;
    logic [DW-1:0]     s2_reg, s2_next;
    logic [DW-1:0]     rhs_reg, rhs_next;
    logic              last_row_reg, last_row_next;

    logic [WW-1:0]     piv_reg, piv_next;
    logic [WW-1:0]     u1_reg, u1_next;
    logic [WW-1:0]     f_reg, f_next;
    logic [WW-1:0]     m_reg, m_next;
    logic [WW-1:0]     acc_reg, acc_next;
    logic [63:0]       hp_reg, hp_next;

    logic [DW-1:0]     prev_m_reg, prev_m_next;
    logic [CW-1:0]     row_count_reg, row_count_next;
    logic [63:0]       det_reg, det_next;
    blu_pkg::err_t     sticky_reg, sticky_next;

    logic [CW-1:0]     k_reg, k_next;
    logic [DW-1:0]     y1_reg, y1_next;
    logic [DW-1:0]     y2_reg, y2_next;

    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     sol_reg, sol_next;
    logic [blu_pkg::IDX_W-1:0] ridx_reg, ridx_next;
    logic [63:0]       det_out_reg, det_out_next;
    blu_pkg::err_t     err_out_reg, err_out_next;
    logic              last_out_reg, last_out_next;

    // band store ports
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              row_we;
    logic              y_we;
    logic [DW-1:0]     y_wdata;
    logic [DW-1:0]     piv_rd, u1_rd, s2_rd, f_rd, y_rd;

    // shared serial unit
    blu_pkg::su_req_t  su_req;
    logic [DW-1:0]     su_a, su_b;
    logic              su_neg;
    logic              su_done;
    logic [63:0]       su_res;
    logic [WW-1:0]     qm, qd;

    logic              row_zero;
    logic [DW-1:0]     u1_op, s2_op, f_op;
    logic [63:0]       det_mag;
    logic [WW-1:0]     u1_eff;

    assign row_zero = (row_count_reg == '0);
    assign u1_op    = row_zero ? '0 : u1_rd;
    assign s2_op    = row_zero ? '0 : s2_rd;
    assign f_op     = row_zero ? '0 : f_rd;
    assign det_mag  = det_reg[63] ? (~det_reg + 64'd1) : det_reg;
    assign qm       = blu_pkg::qmul_res(su_res, su_neg);
    assign qd       = blu_pkg::qdiv_res(su_res, su_neg);
    assign u1_eff   = last_row_reg ? '0 : u1_reg;

    // band stores: pivot, reduced super-one, super-two, forward rhs, solution
    blu_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_piv_ram (
        .clk(clk), .we(row_we), .waddr(wr_addr), .wdata(piv_reg[DW-1:0]),
        .raddr(rd_addr), .rdata(piv_rd)
    );
    blu_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_u1_ram (
        .clk(clk), .we(row_we), .waddr(wr_addr), .wdata(u1_reg[DW-1:0]),
        .raddr(rd_addr), .rdata(u1_rd)
    );
    blu_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_s2_ram (
        .clk(clk), .we(row_we), .waddr(wr_addr), .wdata(s2_reg),
        .raddr(rd_addr), .rdata(s2_rd)
    );
    blu_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_f_ram (
        .clk(clk), .we(row_we), .waddr(wr_addr), .wdata(f_reg[DW-1:0]),
        .raddr(rd_addr), .rdata(f_rd)
    );
    blu_ram #(.WIDTH(DW), .DEPTH(MAX_ROWS)) u_y_ram (
        .clk(clk), .we(y_we), .waddr(wr_addr), .wdata(y_wdata),
        .raddr(rd_addr), .rdata(y_rd)
    );

    blu_serial_unit u_su (
        .clk(clk), .rst_n(rst_n), .req(su_req), .opa(su_a), .opb(su_b),
        .done(su_done), .result(su_res)
    );

    // store addressing: row phase reads the previous row, otherwise row k
    always_comb
    begin
        case (state_reg)
            blu_pkg::ST_ROW_RD, blu_pkg::ST_ROW_M1, blu_pkg::ST_ROW_M2,
            blu_pkg::ST_ROW_M3:
            begin
                rd_addr = AW'(row_count_reg - 1'b1);
            end
            default:
            begin
                rd_addr = AW'(k_reg);
            end
        endcase
        wr_addr = (state_reg == blu_pkg::ST_ROW_WR) ? AW'(row_count_reg) : AW'(k_reg);
    end

    // serial unit operand selection
    always_comb
    begin
        su_a   = '0;
        su_b   = '0;
        su_neg = 1'b0;
        case (state_reg)
            blu_pkg::ST_ROW_M1:
            begin
                su_a   = blu_pkg::mag32(u1_op);
                su_b   = blu_pkg::mag32(prev_m_reg);
                su_neg = u1_op[DW-1] ^ prev_m_reg[DW-1];
            end
            blu_pkg::ST_ROW_M2:
            begin
                su_a   = blu_pkg::mag32(s2_op);
                su_b   = blu_pkg::mag32(prev_m_reg);
                su_neg = s2_op[DW-1] ^ prev_m_reg[DW-1];
            end
            blu_pkg::ST_ROW_M3:
            begin
                su_a   = blu_pkg::mag32(f_op);
                su_b   = blu_pkg::mag32(prev_m_reg);
                su_neg = f_op[DW-1] ^ prev_m_reg[DW-1];
            end
            blu_pkg::ST_ROW_DIV:
            begin
                su_a   = blu_pkg::mag32(sub_reg);
                su_b   = blu_pkg::mag32(piv_reg[DW-1:0]);
                su_neg = sub_reg[DW-1] ^ piv_reg[WW-1];
            end
            blu_pkg::ST_DET_HI:
            begin
                su_a = det_mag[63:32];
                su_b = blu_pkg::mag32(piv_reg[DW-1:0]);
            end
            blu_pkg::ST_DET_LO:
            begin
                su_a   = det_mag[31:0];
                su_b   = blu_pkg::mag32(piv_reg[DW-1:0]);
                su_neg = det_reg[63] ^ piv_reg[WW-1];
            end
            blu_pkg::ST_BS_M1:
            begin
                su_a   = blu_pkg::mag32(u1_rd);
                su_b   = blu_pkg::mag32(y1_reg);
                su_neg = u1_rd[DW-1] ^ y1_reg[DW-1];
            end
            blu_pkg::ST_BS_M2:
            begin
                su_a   = blu_pkg::mag32(s2_rd);
                su_b   = blu_pkg::mag32(y2_reg);
                su_neg = s2_rd[DW-1] ^ y2_reg[DW-1];
            end
            blu_pkg::ST_BS_DIV:
            begin
                su_a   = blu_pkg::mag32(acc_reg[DW-1:0]);
                su_b   = blu_pkg::mag32(piv_rd);
                su_neg = acc_reg[WW-1] ^ piv_rd[DW-1];
            end
            default:
            begin
                su_a   = '0;
                su_b   = '0;
                su_neg = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blu_pkg::ST_IDLE;
            launched_reg  <= 1'b0;
            prev_m_reg    <= '0;
            row_count_reg <= '0;
            det_reg       <= blu_pkg::DET_ONE;
            sticky_reg    <= blu_pkg::ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launched_reg  <= launched_next;
            prev_m_reg    <= prev_m_next;
            row_count_reg <= row_count_next;
            det_reg       <= det_next;
            sticky_reg    <= sticky_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sub_reg      <= sub_next;
        diag_reg     <= diag_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        rhs_reg      <= rhs_next;
        last_row_reg <= last_row_next;
        piv_reg      <= piv_next;
        u1_reg       <= u1_next;
        f_reg        <= f_next;
        m_reg        <= m_next;
        acc_reg      <= acc_next;
        hp_reg       <= hp_next;
        k_reg        <= k_next;
        y1_reg       <= y1_next;
        y2_reg       <= y2_next;
        sol_reg      <= sol_next;
        ridx_reg     <= ridx_next;
        det_out_reg  <= det_out_next;
        err_out_reg  <= err_out_next;
        last_out_reg <= last_out_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        launched_next  = launched_reg;
        sub_next       = sub_reg;
        diag_next      = diag_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        rhs_next       = rhs_reg;
        last_row_next  = last_row_reg;
        piv_next       = piv_reg;
        u1_next        = u1_reg;
        f_next         = f_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        hp_next        = hp_reg;
        prev_m_next    = prev_m_reg;
        row_count_next = row_count_reg;
        det_next       = det_reg;
        sticky_next    = sticky_reg;
        k_next         = k_reg;
        y1_next        = y1_reg;
        y2_next        = y2_reg;
        out_valid_next = out_valid_reg;
        sol_next       = sol_reg;
        ridx_next      = ridx_reg;
        det_out_next   = det_out_reg;
        err_out_next   = err_out_reg;
        last_out_next  = last_out_reg;
        row_we         = 1'b0;
        y_we           = 1'b0;
        y_wdata        = qd[DW-1:0];
        su_req.start   = 1'b0;
        su_req.op      = blu_pkg::OP_MUL;

        case (state_reg)
            // take a row request
            blu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sub_next      = sub_diag;
                    diag_next     = diag;
                    s1_next       = super_one;
                    s2_next       = super_two;
                    rhs_next      = rhs;
                    last_row_next = last_row;
                    if (sticky_reg != blu_pkg::ERR_NONE)
                    begin
                        state_next = blu_pkg::ST_POST;
                    end
                    else if (row_count_reg >= CW'(MAX_ROWS))
                    begin
                        sticky_next = blu_pkg::ERR_ROW_LIMIT;
                        state_next  = blu_pkg::ST_POST;
                    end
                    else
                    begin
                        state_next = blu_pkg::ST_ROW_RD;
                    end
                end
            end

            // previous row entries arrive from the stores
            blu_pkg::ST_ROW_RD:
            begin
                state_next = blu_pkg::ST_ROW_M1;
            end

            // pivot = diag - l * u1[j-1]
            blu_pkg::ST_ROW_M1:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    piv_next      = blu_pkg::sext32(diag_reg) - qm;
                    state_next    = blu_pkg::ST_ROW_M2;
                end
            end

            // u1 = super_one - l * super_two[j-1]
            blu_pkg::ST_ROW_M2:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    u1_next       = blu_pkg::sext32(s1_reg) - qm;
                    state_next    = blu_pkg::ST_ROW_M3;
                end
            end

            // f = rhs - l * f[j-1]
            blu_pkg::ST_ROW_M3:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    f_next        = blu_pkg::sext32(rhs_reg) - qm;
                    state_next    = blu_pkg::ST_ROW_CHK;
                end
            end

            // range and zero pivot checks
            blu_pkg::ST_ROW_CHK:
            begin
                u1_next = u1_eff;
                if (!blu_pkg::fits32(piv_reg) || !blu_pkg::fits32(u1_eff) ||
                    !blu_pkg::fits32(f_reg))
                begin
                    sticky_next = blu_pkg::ERR_SATURATE;
                    state_next  = blu_pkg::ST_POST;
                end
                else if (piv_reg == '0)
                begin
                    sticky_next = blu_pkg::ERR_ZERO_PIVOT;
                    state_next  = blu_pkg::ST_POST;
                end
                else if (!last_row_reg)
                begin
                    state_next = blu_pkg::ST_ROW_DIV;
                end
                else
                begin
                    m_next     = '0;
                    state_next = blu_pkg::ST_DET_HI;
                end
            end

            // multiplier for the next row = sub_diag / pivot
            blu_pkg::ST_ROW_DIV:
            begin
                su_req.op = blu_pkg::OP_DIV;
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    if (!blu_pkg::fits32(qd))
                    begin
                        sticky_next = blu_pkg::ERR_SATURATE;
                        state_next  = blu_pkg::ST_POST;
                    end
                    else
                    begin
                        m_next     = qd;
                        state_next = blu_pkg::ST_DET_HI;
                    end
                end
            end

            // high half of determinant times pivot
            blu_pkg::ST_DET_HI:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    hp_next       = su_res;
                    state_next    = blu_pkg::ST_DET_LO;
                end
            end

            // low half, then round and clamp
            blu_pkg::ST_DET_LO:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    det_next      = blu_pkg::det_update(hp_reg, su_res, su_neg);
                    state_next    = blu_pkg::ST_ROW_WR;
                end
            end

            // commit the row
            blu_pkg::ST_ROW_WR:
            begin
                row_we         = 1'b1;
                prev_m_next    = m_reg[DW-1:0];
                row_count_next = row_count_reg + 1'b1;
                state_next     = blu_pkg::ST_POST;
            end

            // after a row: wait for more, report an error or solve
            blu_pkg::ST_POST:
            begin
                if (!last_row_reg)
                begin
                    state_next = blu_pkg::ST_IDLE;
                end
                else if (sticky_reg != blu_pkg::ERR_NONE)
                begin
                    sol_next       = '0;
                    ridx_next      = '0;
                    det_out_next   = '0;
                    err_out_next   = sticky_reg;
                    last_out_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = blu_pkg::ST_OUT_WAIT;
                end
                else
                begin
                    k_next     = row_count_reg - 1'b1;
                    y1_next    = '0;
                    y2_next    = '0;
                    state_next = blu_pkg::ST_BS_RD;
                end
            end

            // back substitution: fetch row k
            blu_pkg::ST_BS_RD:
            begin
                state_next = blu_pkg::ST_BS_M1;
            end

            // acc = f[k] - u1[k] * y[k+1]
            blu_pkg::ST_BS_M1:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    acc_next      = blu_pkg::sext32(f_rd) - qm;
                    state_next    = blu_pkg::ST_BS_M2;
                end
            end

            // acc -= super_two[k] * y[k+2]
            blu_pkg::ST_BS_M2:
            begin
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    acc_next      = acc_reg - qm;
                    state_next    = blu_pkg::ST_BS_CHK;
                end
            end

            blu_pkg::ST_BS_CHK:
            begin
                if (!blu_pkg::fits32(acc_reg))
                begin
                    sticky_next    = blu_pkg::ERR_SATURATE;
                    sol_next       = '0;
                    ridx_next      = '0;
                    det_out_next   = '0;
                    err_out_next   = blu_pkg::ERR_SATURATE;
                    last_out_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = blu_pkg::ST_OUT_WAIT;
                end
                else
                begin
                    state_next = blu_pkg::ST_BS_DIV;
                end
            end

            // y[k] = acc / pivot[k]
            blu_pkg::ST_BS_DIV:
            begin
                su_req.op = blu_pkg::OP_DIV;
                if (!launched_reg)
                begin
                    su_req.start  = 1'b1;
                    launched_next = 1'b1;
                end
                else if (su_done)
                begin
                    launched_next = 1'b0;
                    if (!blu_pkg::fits32(qd))
                    begin
                        sticky_next    = blu_pkg::ERR_SATURATE;
                        sol_next       = '0;
                        ridx_next      = '0;
                        det_out_next   = '0;
                        err_out_next   = blu_pkg::ERR_SATURATE;
                        last_out_next  = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = blu_pkg::ST_OUT_WAIT;
                    end
                    else
                    begin
                        y_we    = 1'b1;
                        y2_next = y1_reg;
                        y1_next = qd[DW-1:0];
                        if (k_reg == '0)
                        begin
                            k_next     = row_count_reg - 1'b1;
                            state_next = blu_pkg::ST_EMIT_RD;
                        end
                        else
                        begin
                            k_next     = k_reg - 1'b1;
                            state_next = blu_pkg::ST_BS_RD;
                        end
                    end
                end
            end

            // read solution element k
            blu_pkg::ST_EMIT_RD:
            begin
                state_next = blu_pkg::ST_EMIT_LOAD;
            end

            blu_pkg::ST_EMIT_LOAD:
            begin
                sol_next       = y_rd;
                ridx_next      = blu_pkg::IDX_W'(k_reg);
                det_out_next   = det_reg;
                err_out_next   = blu_pkg::ERR_NONE;
                last_out_next  = (k_reg == '0);
                out_valid_next = 1'b1;
                state_next     = blu_pkg::ST_OUT_WAIT;
            end

            // hold the result until the receiver takes it
            blu_pkg::ST_OUT_WAIT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (last_out_reg)
                    begin
                        prev_m_next    = '0;
                        row_count_next = '0;
                        det_next       = blu_pkg::DET_ONE;
                        sticky_next    = blu_pkg::ERR_NONE;
                        state_next     = blu_pkg::ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg - 1'b1;
                        state_next = blu_pkg::ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = blu_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_ready    = (state_reg == blu_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign solution    = sol_reg;
    assign row_index   = ridx_reg;
    assign determinant = det_out_reg;
    assign error_code  = err_out_reg;
    assign last        = last_out_reg;

endmodule

`default_nettype wire

@@ rtl/blu_checker.sv @@
// port-level checker for the banded lu solver, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "banded_lu_linear_solver_assert.svh"

module blu_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        last_row,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [blu_pkg::DATA_W-1:0]  solution,
    input wire logic [blu_pkg::IDX_W-1:0]   row_index,
    input wire logic [blu_pkg::DET_W-1:0]   determinant,
    input wire logic [1:0]                  error_code,
    input wire logic                        last
);

    // a stalled result keeps its payload
    `BLU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(solution) && $stable(row_index) && $stable(determinant), "stalled result changed")

    // rows are never taken while a result is pending
    `BLU_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid, "row request open during output")

    // an error result carries an empty payload and ends the solve
    `BLU_ASSERT_IMP(a_err_payload, clk, rst_n, out_valid && (error_code != blu_pkg::ERR_NONE), last && (solution == '0) && (row_index == '0) && (determinant == '0), "error result payload not clear")

    // a middle row never produces output in the next cycle
    `BLU_ASSERT_NXT(a_mid_row_quiet, clk, rst_n, in_valid && in_ready && !last_row, !out_valid, "output after a middle row")

    // the final result is row zero
    `BLU_ASSERT_IMP(a_last_row0, clk, rst_n, out_valid && last, row_index == '0, "final result not row zero")

endmodule

bind banded_lu_linear_solver blu_checker u_blu_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .last_row(last_row),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .solution(solution),
    .row_index(row_index),
    .determinant(determinant),
    .error_code(error_code),
    .last(last)
);

`default_nettype wire
